/* sv/doubly_linked_list_engine_defines.svh */
// Assertion macros shared by the linked list engine modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DLL_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define DLL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define DLL_ASSERT_SAME(lbl, ck, rn, ante, cons, msg)
`define DLL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

/* sv/dlle_pkg.sv */
// Shared types for the linked list engine: operation and status codes,
// and the command and status groups between controller and datapath.
package dlle_pkg;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_DISPLAY = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ITEM      = 3'd4
    } status_t;

    typedef struct packed {
        logic    load_value;
        logic    rd_head;
        logic    rd_next;
        logic    scan_clr;
        logic    scan_inc;
        logic    ins_write;
        logic    ins_link;
        logic    unlink;
        logic    emit;
        status_t status;
        logic    last;
    } cmd_t;

    typedef struct packed {
        logic head_valid;
        logic next_valid;
        logic hit;
        logic walk_end;
        logic slot_free;
        logic scan_end;
    } stat_t;

endpackage

/* sv/dlle_datapath.sv */
// Datapath of the linked list engine: node stores, head pointer, free map,
// walk and scan counters and the result register. Uses dlle_pkg.
`include "doubly_linked_list_engine_defines.svh"

module dlle_datapath #(
    parameter int MAX_NODES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [31:0]  value,
    input  dlle_pkg::cmd_t      cmd,
    output dlle_pkg::stat_t     stat,
    output logic                result_strobe,
    output logic [2:0]          status,
    output logic signed [31:0]  item_value,
    output logic                last
);

    localparam int LINK_W = $clog2(MAX_NODES + 1);
    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_NODES);
    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(MAX_NODES - 1);

    logic signed [31:0] value_mem [MAX_NODES];
    logic [LINK_W-1:0]  next_mem  [MAX_NODES];
    logic [LINK_W-1:0]  prev_mem  [MAX_NODES];

    logic signed [31:0] value_reg;
    logic signed [31:0] rd_value_reg;
    logic [LINK_W-1:0]  rd_next_reg;
    logic [LINK_W-1:0]  rd_prev_reg;
    logic [ADDR_W-1:0]  cur_reg;

    logic [LINK_W-1:0]    head_reg, head_next;
    logic [MAX_NODES-1:0] in_use_reg, in_use_next;
    logic [ADDR_W-1:0]    steps_reg, steps_next;
    logic [ADDR_W-1:0]    scan_reg, scan_next;

    logic                 strobe_reg;
    dlle_pkg::status_t    status_reg;
    logic signed [31:0]   item_value_reg, item_value_next;
    logic                 last_reg;

    logic head_valid, next_valid, prev_valid, cur_is_head;
    logic [LINK_W-1:0] head_norm, next_norm, prev_norm;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              next_we, prev_we;
    logic [ADDR_W-1:0] next_waddr, prev_waddr;
    logic [LINK_W-1:0] next_wdata, prev_wdata;

    // Links are either a slot index or the null marker; anything at or
    // above the slot count ends a walk.
    assign head_valid  = head_reg < NULL_LINK;
    assign next_valid  = rd_next_reg < NULL_LINK;
    assign prev_valid  = rd_prev_reg < NULL_LINK;
    assign cur_is_head = LINK_W'(cur_reg) == head_reg;
    assign head_norm   = head_valid ? head_reg : NULL_LINK;
    assign next_norm   = next_valid ? rd_next_reg : NULL_LINK;
    assign prev_norm   = prev_valid ? rd_prev_reg : NULL_LINK;

    assign stat.head_valid = head_valid;
    assign stat.next_valid = next_valid;
    assign stat.hit        = rd_value_reg == value_reg;
    assign stat.walk_end   = steps_reg == LAST_IDX;
    assign stat.slot_free  = !in_use_reg[scan_reg];
    assign stat.scan_end   = scan_reg == LAST_IDX;

    // The walk follows the registered forward link, so one node is read
    // per cycle.
    assign rd_en   = cmd.rd_head | cmd.rd_next;
    assign rd_addr = cmd.rd_head ? head_reg[ADDR_W-1:0] : rd_next_reg[ADDR_W-1:0];

    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = scan_reg;
        next_wdata = head_norm;
        if (cmd.ins_write)
        begin
            next_we = 1'b1;
        end
        else if (cmd.unlink && !cur_is_head && prev_valid)
        begin
            next_we    = 1'b1;
            next_waddr = rd_prev_reg[ADDR_W-1:0];
            next_wdata = next_norm;
        end
    end

    always_comb
    begin
        prev_we    = 1'b0;
        prev_waddr = scan_reg;
        prev_wdata = NULL_LINK;
        if (cmd.ins_write)
        begin
            prev_we = 1'b1;
        end
        else if (cmd.ins_link && head_valid)
        begin
            prev_we    = 1'b1;
            prev_waddr = head_reg[ADDR_W-1:0];
            prev_wdata = LINK_W'(scan_reg);
        end
        else if (cmd.unlink && next_valid)
        begin
            prev_we    = 1'b1;
            prev_waddr = rd_next_reg[ADDR_W-1:0];
            prev_wdata = cur_is_head ? NULL_LINK : prev_norm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            value_mem[scan_reg] <= value_reg;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (rd_en)
        begin
            rd_value_reg <= value_mem[rd_addr];
            rd_next_reg  <= next_mem[rd_addr];
            rd_prev_reg  <= prev_mem[rd_addr];
            cur_reg      <= rd_addr;
        end
        if (cmd.load_value)
        begin
            value_reg <= value;
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        in_use_next = in_use_reg;
        if (cmd.ins_link)
        begin
            head_next             = LINK_W'(scan_reg);
            in_use_next[scan_reg] = 1'b1;
        end
        else if (cmd.unlink)
        begin
            if (cur_is_head)
            begin
                head_next = next_norm;
            end
            in_use_next[cur_reg] = 1'b0;
        end
    end

    always_comb
    begin
        steps_next = steps_reg;
        if (cmd.rd_head)
        begin
            steps_next = '0;
        end
        else if (cmd.rd_next)
        begin
            steps_next = steps_reg + 1'b1;
        end
        scan_next = scan_reg;
        if (cmd.scan_clr)
        begin
            scan_next = '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_next = scan_reg + 1'b1;
        end
    end

    assign item_value_next = (cmd.status == dlle_pkg::ST_ITEM) ? rd_value_reg : 32'sd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= NULL_LINK;
            in_use_reg     <= '0;
            steps_reg      <= '0;
            scan_reg       <= '0;
            strobe_reg     <= 1'b0;
            status_reg     <= dlle_pkg::ST_DONE;
            item_value_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            in_use_reg     <= in_use_next;
            steps_reg      <= steps_next;
            scan_reg       <= scan_next;
            strobe_reg     <= cmd.emit;
            status_reg     <= cmd.status;
            item_value_reg <= item_value_next;
            last_reg       <= cmd.last;
        end
    end

    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign item_value    = item_value_reg;
    assign last          = last_reg;

    `DLL_ASSERT_NEXT(a_insert_takes_slot, clk, rst_n, cmd.ins_link, $countones(in_use_reg) == $past($countones(in_use_reg)) + 1, "insert did not take exactly one slot")
    `DLL_ASSERT_NEXT(a_delete_frees_slot, clk, rst_n, cmd.unlink, !in_use_reg[$past(cur_reg)], "deleted slot still marked in use")
    `DLL_ASSERT_SAME(a_head_in_use, clk, rst_n, head_valid, |in_use_reg, "list has a head but no slot in use")

endmodule

/* sv/dlle_ctrl.sv */
// Controller of the linked list engine: sequences insert, delete and
// display over the datapath. Uses dlle_pkg.
`include "doubly_linked_list_engine_defines.svh"

module dlle_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      op,
    input  dlle_pkg::stat_t stat,
    output dlle_pkg::cmd_t  cmd,
    output logic            busy
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_INS_SCAN  = 7'b0000010,
        S_INS_WRITE = 7'b0000100,
        S_INS_LINK  = 7'b0001000,
        S_DEL_WALK  = 7'b0010000,
        S_DEL_FIX   = 7'b0100000,
        S_DISP_WALK = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = dlle_pkg::ST_DONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_value = 1'b1;
                    case (dlle_pkg::op_t'(op))
                        dlle_pkg::OP_INSERT:
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_INS_SCAN;
                        end
                        dlle_pkg::OP_DELETE:
                        begin
                            if (stat.head_valid)
                            begin
                                cmd.rd_head = 1'b1;
                                state_next  = S_DEL_WALK;
                            end
                            else
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = dlle_pkg::ST_EMPTY;
                                cmd.last   = 1'b1;
                            end
                        end
                        dlle_pkg::OP_DISPLAY:
                        begin
                            if (stat.head_valid)
                            begin
                                cmd.rd_head = 1'b1;
                                state_next  = S_DISP_WALK;
                            end
                            else
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = dlle_pkg::ST_EMPTY;
                                cmd.last   = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_SCAN:
            begin
                if (stat.slot_free)
                begin
                    state_next = S_INS_WRITE;
                end
                else if (stat.scan_end)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = dlle_pkg::ST_FULL;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_INS_WRITE:
            begin
                cmd.ins_write = 1'b1;
                state_next    = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                cmd.ins_link = 1'b1;
                cmd.emit     = 1'b1;
                cmd.last     = 1'b1;
                state_next   = S_IDLE;
            end
            S_DEL_WALK:
            begin
                if (stat.hit)
                begin
                    state_next = S_DEL_FIX;
                end
                else if (!stat.next_valid || stat.walk_end)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = dlle_pkg::ST_NOT_FOUND;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_DEL_FIX:
            begin
                cmd.unlink = 1'b1;
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            S_DISP_WALK:
            begin
                cmd.emit   = 1'b1;
                cmd.status = dlle_pkg::ST_ITEM;
                if (!stat.next_valid || stat.walk_end)
                begin
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    `DLL_ASSERT_NEXT(a_last_ends_op, clk, rst_n, cmd.emit && cmd.last, state_reg == S_IDLE, "final beat did not return the controller to idle")
    `DLL_ASSERT_SAME(a_fix_after_walk, clk, rst_n, state_reg == S_DEL_FIX, $past(state_reg) == S_DEL_WALK, "unlink entered without a matching walk")

endmodule

/* sv/doubly_linked_list_engine.sv */
// Top level of the linked list engine: controller plus datapath.
// Depends on dlle_pkg, dlle_ctrl and dlle_datapath.
//
// A command is taken when start is high and busy is low. Every result beat
// shows on result_strobe for one cycle and cannot be held off, so the receiver
// must take it. Insert scans the free map one slot per cycle for the lowest
// free slot, then writes the node and links it in as the new head; a full
// list answers once the last slot is scanned. Delete reads one linked node
// per cycle from the node store and unlinks a match in a separate fix step.
// Display emits one beat per node on back-to-back cycles, at most MAX_NODES
// beats, limited by the single read port of the node store. Empty list
// answers and the unused op code finish without leaving idle. No clearing
// pass runs after reset.
module doubly_linked_list_engine #(
    parameter int MAX_NODES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    input  logic signed [31:0] value,
    output logic               busy,
    output logic               result_strobe,
    output logic [2:0]         status,
    output logic signed [31:0] item_value,
    output logic               last
);

    dlle_pkg::cmd_t  cmd;
    dlle_pkg::stat_t stat;

    dlle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dlle_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (value),
        .cmd           (cmd),
        .stat          (stat),
        .result_strobe (result_strobe),
        .status        (status),
        .item_value    (item_value),
        .last          (last)
    );

endmodule

/* bench/testbench.sv */
// Self-checking bench for doubly_linked_list_engine: a directed table, then random
// insert, delete, display and unused-op commands checked beat by beat against a list predictor.
// Depends on dlle_pkg and the engine RTL.
module testbench;

    localparam int NODES = 16;
    localparam logic [4:0] NIL = 5'(NODES);
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 125;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int NUM_ROWS = 23;

    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_ONE,
        CHECK_NONE
    } check_t;

    typedef struct packed {
        dlle_pkg::status_t status;
        logic [31:0]       item_value;
        logic              last;
    } beat_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        int          reps;
        check_t      check;
        beat_t       beat;
    } stim_row_t;

    localparam beat_t DONE_BEAT      = '{dlle_pkg::ST_DONE, 32'd0, 1'b1};
    localparam beat_t EMPTY_BEAT     = '{dlle_pkg::ST_EMPTY, 32'd0, 1'b1};
    localparam beat_t FULL_BEAT      = '{dlle_pkg::ST_FULL, 32'd0, 1'b1};
    localparam beat_t NOT_FOUND_BEAT = '{dlle_pkg::ST_NOT_FOUND, 32'd0, 1'b1};
    localparam beat_t NO_BEAT        = '{dlle_pkg::ST_DONE, 32'd0, 1'b0};

    // Fill to capacity, overflow, and empty again, touching head, middle and tail deletes.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{dlle_pkg::OP_DISPLAY, 32'h0000_0000, 1,  CHECK_ONE,   EMPTY_BEAT},
        '{dlle_pkg::OP_DELETE,  32'h7FFF_FFFF, 1,  CHECK_ONE,   EMPTY_BEAT},
        '{OP_UNUSED,            32'hFFFF_FFFF, 1,  CHECK_NONE,  NO_BEAT},
        '{dlle_pkg::OP_INSERT,  32'h7FFF_FFFF, 1,  CHECK_ONE,   DONE_BEAT},
        '{dlle_pkg::OP_INSERT,  32'h8000_0000, 1,  CHECK_ONE,   DONE_BEAT},
        '{dlle_pkg::OP_INSERT,  32'h0000_0000, 1,  CHECK_ONE,   DONE_BEAT},
        '{dlle_pkg::OP_INSERT,  32'hFFFF_FFFF, 1,  CHECK_ONE,   DONE_BEAT},
        '{dlle_pkg::OP_DISPLAY, 32'h0000_0000, 1,  CHECK_MODEL, NO_BEAT},
        '{dlle_pkg::OP_DELETE,  32'h0000_0005, 1,  CHECK_ONE,   NOT_FOUND_BEAT},
        '{dlle_pkg::OP_DELETE,  32'h0000_0000, 1,  CHECK_ONE,   DONE_BEAT},
        '{dlle_pkg::OP_DELETE,  32'h7FFF_FFFF, 1,  CHECK_ONE,   DONE_BEAT},
        '{dlle_pkg::OP_DELETE,  32'hFFFF_FFFF, 1,  CHECK_ONE,   DONE_BEAT},
        '{dlle_pkg::OP_INSERT,  32'h5A5A_5A5A, 15, CHECK_MODEL, NO_BEAT},
        '{dlle_pkg::OP_INSERT,  32'h0000_0000, 1,  CHECK_ONE,   FULL_BEAT},
        '{dlle_pkg::OP_DISPLAY, 32'h0000_0000, 1,  CHECK_MODEL, NO_BEAT},
        '{dlle_pkg::OP_DELETE,  32'h5A5A_5A5A, 1,  CHECK_MODEL, NO_BEAT},
        '{dlle_pkg::OP_INSERT,  32'h1234_5678, 1,  CHECK_MODEL, NO_BEAT},
        '{dlle_pkg::OP_DELETE,  32'h8000_0000, 1,  CHECK_ONE,   DONE_BEAT},
        '{dlle_pkg::OP_DISPLAY, 32'hA5A5_A5A5, 1,  CHECK_MODEL, NO_BEAT},
        '{dlle_pkg::OP_DELETE,  32'h5A5A_5A5A, 14, CHECK_MODEL, NO_BEAT},
        '{OP_UNUSED,            32'h0000_0000, 1,  CHECK_NONE,  NO_BEAT},
        '{dlle_pkg::OP_DELETE,  32'h1234_5678, 1,  CHECK_MODEL, NO_BEAT},
        '{dlle_pkg::OP_DISPLAY, 32'h0000_0000, 1,  CHECK_ONE,   EMPTY_BEAT}
    };

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               busy;
    logic               result_strobe;
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic               last;

    // Expectation attached to the command currently on the inputs.
    check_t drv_check;
    beat_t  drv_beat;

    // Predicted list contents.
    logic [31:0]      node_val [NODES];
    logic [4:0]       fwd_link [NODES];
    logic [4:0]       bwd_link [NODES];
    logic [NODES-1:0] slot_used;
    logic [4:0]       head;

    beat_t fresh_beats [$];
    beat_t expected_beats [$];
    int    items_taken;
    int    errors;
    int    idle_cycles;
    logic [31:0] value_pool [6];

    doubly_linked_list_engine #(
        .MAX_NODES(NODES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .value        (value),
        .busy         (busy),
        .result_strobe(result_strobe),
        .status       (status),
        .item_value   (item_value),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic void push_beat(dlle_pkg::status_t s, logic [31:0] v, logic l);
        beat_t b;
        b.status = s;
        b.item_value = v;
        b.last = l;
        fresh_beats.push_back(b);
    endfunction

    // Applies one command to the predicted list and queues the beats it yields.
    function automatic void apply_list_op(logic [1:0] opc, logic [31:0] v);
        int slot;
        int steps;
        int n;
        bit found;
        logic [4:0] cur;
        logic [4:0] nx;
        logic [4:0] pv;
        case (opc)
            dlle_pkg::OP_INSERT:
            begin
                slot = NODES;
                for (int i = NODES - 1; i >= 0; i--)
                begin
                    if (!slot_used[4'(i)])
                        slot = i;
                end
                if (slot == NODES)
                    push_beat(dlle_pkg::ST_FULL, 32'd0, 1'b1);
                else
                begin
                    node_val[4'(slot)] = v;
                    slot_used[4'(slot)] = 1'b1;
                    bwd_link[4'(slot)] = NIL;
                    fwd_link[4'(slot)] = head;
                    if (head != NIL)
                        bwd_link[head[3:0]] = 5'(slot);
                    head = 5'(slot);
                    push_beat(dlle_pkg::ST_DONE, 32'd0, 1'b1);
                end
            end
            dlle_pkg::OP_DELETE:
            begin
                if (head == NIL)
                    push_beat(dlle_pkg::ST_EMPTY, 32'd0, 1'b1);
                else
                begin
                    cur = head;
                    found = 1'b0;
                    for (steps = 0; steps < NODES && cur < NIL && !found; steps++)
                    begin
                        if (node_val[cur[3:0]] == v)
                            found = 1'b1;
                        else
                            cur = fwd_link[cur[3:0]];
                    end
                    if (found)
                    begin
                        nx = fwd_link[cur[3:0]];
                        pv = bwd_link[cur[3:0]];
                        if (cur == head)
                        begin
                            head = nx;
                            if (head != NIL)
                                bwd_link[head[3:0]] = NIL;
                        end
                        else
                        begin
                            if (pv != NIL)
                                fwd_link[pv[3:0]] = nx;
                            if (nx != NIL)
                                bwd_link[nx[3:0]] = pv;
                        end
                        slot_used[cur[3:0]] = 1'b0;
                        push_beat(dlle_pkg::ST_DONE, 32'd0, 1'b1);
                    end
                    else
                        push_beat(dlle_pkg::ST_NOT_FOUND, 32'd0, 1'b1);
                end
            end
            dlle_pkg::OP_DISPLAY:
            begin
                if (head == NIL)
                    push_beat(dlle_pkg::ST_EMPTY, 32'd0, 1'b1);
                else
                begin
                    n = 0;
                    cur = head;
                    while (n < NODES && cur < NIL)
                    begin
                        nx = fwd_link[cur[3:0]];
                        push_beat(dlle_pkg::ST_ITEM, node_val[cur[3:0]],
                                  (nx == NIL) || (n + 1 >= NODES));
                        n++;
                        cur = nx;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Command acceptance, beat checking and the watchdog, all on the rising edge.
    always @(posedge clk)
    begin
        beat_t want;
        bit took;
        took = 1'b0;
        if (rst_n && start && !busy)
        begin
            took = 1'b1;
            items_taken++;
            fresh_beats.delete();
            apply_list_op(op, value);
            case (drv_check)
                CHECK_ONE:
                    expected_beats.push_back(drv_beat);
                CHECK_NONE:
                begin
                end
                default:
                begin
                    foreach (fresh_beats[i])
                        expected_beats.push_back(fresh_beats[i]);
                end
            endcase
        end
        if (rst_n && result_strobe)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: status %0d item_value %0d last %0d",
                       status, item_value, last);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    errors++;
                end
                if (item_value !== want.item_value)
                begin
                    $error("item_value: expected %0d, actual %0d",
                           $signed(want.item_value), item_value);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    errors++;
                end
            end
        end
        if (took || result_strobe)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Presents one command from the falling edge on and holds it until it is taken.
    task automatic send_command(input logic [1:0] opc, input logic [31:0] v,
                                input check_t chk, input beat_t b);
        int target;
        target = items_taken + 1;
        start <= 1'b1;
        op <= opc;
        value <= v;
        drv_check <= chk;
        drv_beat <= b;
        while (items_taken < target)
            @(negedge clk);
    endtask

    // Idles the sender when gap is nonzero or drain is set; with drain set it also waits for every expected beat.
    task automatic hold_off(input int gap, input bit drain);
        if (gap > 0 || drain)
            start <= 1'b0;
        repeat (gap)
            @(negedge clk);
        if (drain)
        begin
            while (expected_beats.size() != 0)
                @(negedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Phases lean toward filling, then emptying, then a balanced mix.
    function automatic logic [1:0] pick_op(int phase);
        int r;
        int ins_w;
        int del_w;
        r = $urandom_range(0, 99);
        case (phase)
            0:
            begin
                ins_w = 65;
                del_w = 15;
            end
            1:
            begin
                ins_w = 20;
                del_w = 60;
            end
            default:
            begin
                ins_w = 35;
                del_w = 35;
            end
        endcase
        if (r < ins_w)
            return dlle_pkg::OP_INSERT;
        else if (r < ins_w + del_w)
            return dlle_pkg::OP_DELETE;
        else if (r < 95)
            return dlle_pkg::OP_DISPLAY;
        return OP_UNUSED;
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[3'($urandom_range(0, 5))];
        return $urandom;
    endfunction

    initial
    begin
        int counted;
        int gap;
        logic [1:0] opc;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = dlle_pkg::OP_INSERT;
        value = '0;
        drv_check = CHECK_MODEL;
        drv_beat = NO_BEAT;
        items_taken = 0;
        errors = 0;
        idle_cycles = 0;
        slot_used = '0;
        head = NIL;
        for (int i = 0; i < NODES; i++)
        begin
            node_val[4'(i)] = '0;
            fwd_link[4'(i)] = '0;
            bwd_link[4'(i)] = '0;
        end

        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                send_command(directed_rows[r].op, directed_rows[r].value,
                             directed_rows[r].check, directed_rows[r].beat);
                hold_off(pick_gap(), 1'b0);
            end
        end
        hold_off(0, 1'b1);

        value_pool[0] = 32'h7FFF_FFFF;
        value_pool[1] = 32'h8000_0000;
        for (int i = 2; i < 6; i++)
            value_pool[3'(i)] = $urandom;

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            opc = pick_op((counted / 30) % 3);
            send_command(opc, pick_value(), CHECK_MODEL, NO_BEAT);
            if (opc != OP_UNUSED)
                counted++;
            // A stretch of back-to-back commands with no sender gaps.
            gap = (counted >= 60 && counted < 90) ? 0 : pick_gap();
            hold_off(gap, counted == 100 && opc != OP_UNUSED);
        end

        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (NODES + 8)
            @(negedge clk);

        if (expected_beats.size() != 0)
        begin
            $error("%0d expected beats never arrived", expected_beats.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
